@@ hdl/heaa_pkg.sv @@
// Shared types and constants for the hip extension angle assist block.
// No dependencies; used by heaa_ctrl, heaa_dp and the top level.
package heaa_pkg;

    // Input transaction payload
    typedef struct packed {
        logic signed [15:0] joint_angle;
        logic signed [15:0] joint_velocity;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic signed [8:0] torque_cmd;
        logic              assist_mode;
    } t_out;

    // Configuration register indexes
    localparam logic [2:0] REG_EXT_SP    = 3'd0;
    localparam logic [2:0] REG_FLEX_SP   = 3'd1;
    localparam logic [2:0] REG_PERCENT   = 3'd2;
    localparam logic [2:0] REG_CLEAR     = 3'd3;
    localparam logic [2:0] REG_INIT_MAX  = 3'd4;
    localparam logic [2:0] REG_INIT_MIN  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Assist modes
    localparam logic MODE_EXT  = 1'b0;
    localparam logic MODE_FLEX = 1'b1;

    // 5 degrees in Q3.12 radians (357.44, compared as strictly greater)
    localparam logic signed [15:0] FIVE_DEG_Q12 = 16'sd357;
    localparam logic signed [23:0] PERCENT_SCALE = 24'sd100;

    // Divider geometry: 24-bit dividend magnitude, one quotient bit per cycle
    localparam int NUM_W     = 24;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register file contents
    typedef struct packed {
        logic signed [8:0]  ext_sp;
        logic signed [8:0]  flex_sp;
        logic [6:0]         percent;
        logic               clear_range;
        logic [14:0]        init_max;
        logic signed [15:0] init_min;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture sample and update range
        logic mode_en;   // update mode, form product and divisor
        logic setup_en;  // take magnitudes, seed divider
        logic div_step;  // one restoring division step
        logic out_load;  // write result into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic flex_mode; // mode after update is flexion
    } t_stat;

endpackage

@@ hdl/heaa_ctrl.sv @@
// Sequencer for the hip extension angle assist block.
// Depends on heaa_pkg; drives heaa_dp through t_cmd and reads t_stat.
module heaa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  heaa_pkg::t_stat       i_stat,
    output heaa_pkg::t_cmd        o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MODE   = 5'b00010,
        S_SETUP  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [heaa_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_ovalid, n_ovalid;
    logic                         w_out_free;

    assign w_out_free  = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_ovalid       = r_ovalid && !i_out_ready;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MODE;
                end
            end
            S_MODE: begin
                o_cmd.mode_en = 1'b1;
                n_state       = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup_en = 1'b1;
                n_cnt          = '0;
                n_state        = i_stat.flex_mode ? S_FINISH : S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == heaa_pkg::CNT_W'(heaa_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ hdl/heaa_dp.sv @@
// Datapath: angle range tracking, mode machine, serial divider, output register.
// Depends on heaa_pkg; sequenced by heaa_ctrl.
module heaa_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  heaa_pkg::t_cfg        i_cfg,
    input  heaa_pkg::t_in         i_in_data,
    input  heaa_pkg::t_cmd        i_cmd,
    output heaa_pkg::t_stat       o_stat,
    output heaa_pkg::t_out        o_out_data
);

    // Sample and tracked range
    logic signed [15:0]             r_angle;
    logic signed [15:0]             r_vel;
    logic signed [15:0]             r_max;
    logic signed [15:0]             r_min;
    logic                           r_mode;
    // Product and divisor ahead of the divider
    logic signed [24:0]             r_prod;
    logic signed [15:0]             r_den_s;
    // Divider state
    logic [heaa_pkg::NUM_W-1:0]     r_quo;
    logic [heaa_pkg::DEN_W-1:0]     r_rem;
    logic [heaa_pkg::DEN_W-1:0]     r_den;
    logic                           r_neg;
    logic                           r_zero;
    heaa_pkg::t_out                 r_out;

    logic signed [15:0]             w_base_max, w_base_min;
    logic signed [23:0]             w_lhs, w_rhs;
    logic                           w_next_mode;
    logic signed [24:0]             w_prod_neg;
    logic signed [15:0]             w_den_neg;
    logic [heaa_pkg::DEN_W:0]       w_trial;
    logic [heaa_pkg::DEN_W:0]       w_diff;
    logic [8:0]                     w_q;
    logic signed [8:0]              w_torque;

    // Range base: reload from the initial registers when clearing
    assign w_base_max = i_cfg.clear_range ? $signed({1'b0, i_cfg.init_max}) : r_max;
    assign w_base_min = i_cfg.clear_range ? i_cfg.init_min : r_min;

    // Mode update terms
    assign w_lhs = 24'(r_angle) * heaa_pkg::PERCENT_SCALE;
    assign w_rhs = 24'($signed({1'b0, i_cfg.percent})) * 24'(r_max);

    always_comb begin
        if (r_mode == heaa_pkg::MODE_EXT) begin
            w_next_mode = (r_angle <= 16'sd0) ? heaa_pkg::MODE_FLEX : heaa_pkg::MODE_EXT;
        end else if ((w_lhs > w_rhs) ||
                     ((r_angle > heaa_pkg::FIVE_DEG_Q12) && (r_vel <= 16'sd0))) begin
            w_next_mode = heaa_pkg::MODE_EXT;
        end else begin
            w_next_mode = heaa_pkg::MODE_FLEX;
        end
    end

    // Magnitudes for the unsigned divider
    assign w_prod_neg = -r_prod;
    assign w_den_neg  = -r_den_s;

    // Restoring division step
    assign w_trial = {r_rem, r_quo[heaa_pkg::NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    // Signed quotient, truncated toward zero
    assign w_q      = r_quo[8:0];
    assign w_torque = r_zero ? 9'sd0 : (r_neg ? $signed(-w_q) : $signed(w_q));

    // Mode and range state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= '0;
            r_min  <= '0;
            r_mode <= heaa_pkg::MODE_EXT;
        end else begin
            if (i_cmd.load) begin
                r_max <= (i_in_data.joint_angle > w_base_max) ?
                         i_in_data.joint_angle : w_base_max;
                r_min <= (i_in_data.joint_angle < w_base_min) ?
                         i_in_data.joint_angle : w_base_min;
            end
            if (i_cmd.mode_en) begin
                r_mode <= w_next_mode;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_angle <= i_in_data.joint_angle;
            r_vel   <= i_in_data.joint_velocity;
        end
        if (i_cmd.mode_en) begin
            r_prod  <= 25'(i_cfg.ext_sp) * 25'(r_angle);
            r_den_s <= (r_angle >= 16'sd0) ? r_max : r_min;
        end
        if (i_cmd.setup_en) begin
            r_quo  <= r_prod[24] ? w_prod_neg[heaa_pkg::NUM_W-1:0]
                                 : r_prod[heaa_pkg::NUM_W-1:0];
            r_den  <= r_den_s[15] ? w_den_neg : r_den_s;
            r_rem  <= '0;
            r_neg  <= r_prod[24] ^ r_den_s[15];
            r_zero <= (r_den_s == 16'sd0);
        end
        if (i_cmd.div_step) begin
            if (!w_diff[heaa_pkg::DEN_W]) begin
                r_rem <= w_diff[heaa_pkg::DEN_W-1:0];
                r_quo <= {r_quo[heaa_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[heaa_pkg::DEN_W-1:0];
                r_quo <= {r_quo[heaa_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out.assist_mode <= r_mode;
            r_out.torque_cmd  <= (r_mode == heaa_pkg::MODE_FLEX) ? i_cfg.flex_sp : w_torque;
        end
    end

    assign o_stat.flex_mode = (r_mode == heaa_pkg::MODE_FLEX);
    assign o_out_data       = r_out;

endmodule

@@ hdl/hip_extension_angle_assist_unit.sv @@
// Top level of the hip extension angle assist block: configuration registers,
// sequencer and datapath. Depends on heaa_pkg, heaa_ctrl and heaa_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_data) takes one angle and
//   velocity sample per transaction. Output channel (o_out_valid /
//   i_out_ready, o_out_data) returns one torque command and the assist mode
//   for each sample, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
//   i_cfg_data) writes one register per transaction; it is always ready.
//   Indexes beyond the register list are ignored. Write only while idle.
// Sequence:
//   One sample in flight at a time. In extension mode the result passes
//   through mode update, divider setup, 24 restoring-division steps (one
//   quotient bit per cycle), and the output load. In flexion the divider is
//   skipped. The next sample is taken in the cycle after the result is
//   loaded.
// Reset:
//   Synchronous, active low. The configuration registers, the tracked range
//   and the mode return to zero / extension; the output register is empty.
// Stalls:
//   The result waits in the output register while i_out_ready is low; a
//   following sample may be processed, but it is held before the output
//   load until the register frees.
module hip_extension_angle_assist_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  heaa_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output heaa_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [heaa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [heaa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    heaa_pkg::t_cfg  r_cfg;
    heaa_pkg::t_cmd  w_cmd;
    heaa_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                heaa_pkg::REG_EXT_SP:   r_cfg.ext_sp      <= i_cfg_data[8:0];
                heaa_pkg::REG_FLEX_SP:  r_cfg.flex_sp     <= i_cfg_data[8:0];
                heaa_pkg::REG_PERCENT:  r_cfg.percent     <= i_cfg_data[6:0];
                heaa_pkg::REG_CLEAR:    r_cfg.clear_range <= i_cfg_data[0];
                heaa_pkg::REG_INIT_MAX: r_cfg.init_max    <= i_cfg_data[14:0];
                heaa_pkg::REG_INIT_MIN: r_cfg.init_min    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    heaa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    heaa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for hip_extension_angle_assist_unit: a scoreboard class
// predicts torque and mode per sample; tasks drive the sample and register channels.
// Depends on heaa_pkg and the RTL of the block only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import heaa_pkg::*;

    localparam int RAND_PHASES    = 8;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int DRAIN_CYCLES   = 40;

    // Predicts one result per accepted sample and checks results in order
    class torque_scoreboard;
        logic signed [8:0]  ext_sp;
        logic signed [8:0]  flex_sp;
        logic [6:0]         percent;
        logic               clear_range;
        logic [14:0]        init_max;
        logic signed [15:0] init_min;
        logic               mode_q;
        int                 track_max;
        int                 track_min;
        t_out               pending_cmds[$];
        int                 mismatches;

        function new();
            ext_sp      = '0;
            flex_sp     = '0;
            percent     = '0;
            clear_range = 1'b0;
            init_max    = '0;
            init_min    = '0;
            mode_q      = MODE_EXT;
            track_max   = 0;
            track_min   = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_EXT_SP:   ext_sp = data[8:0];
                REG_FLEX_SP:  flex_sp = data[8:0];
                REG_PERCENT:  percent = data[6:0];
                REG_CLEAR:    clear_range = data[0];
                REG_INIT_MAX: init_max = data[14:0];
                REG_INIT_MIN: init_min = data[15:0];
                default: ;
            endcase
        endfunction

        // Range tracking, mode update, then torque from the new mode
        function void note_sample(t_in s);
            int     ang;
            int     vel;
            longint divisor;
            longint cmd;
            longint lhs;
            longint rhs;
            t_out   exp_res;
            ang = s.joint_angle;
            vel = s.joint_velocity;
            if (clear_range) begin
                track_max = init_max;
                track_min = init_min;
            end
            if (ang > track_max) track_max = ang;
            if (ang < track_min) track_min = ang;
            divisor = (ang >= 0) ? longint'(track_max) : longint'(track_min);

            if (mode_q == MODE_EXT) begin
                if (ang <= 0) mode_q = MODE_FLEX;
            end else begin
                lhs = longint'(PERCENT_SCALE) * longint'(ang);
                rhs = longint'(percent) * longint'(track_max);
                if (lhs > rhs || (ang > FIVE_DEG_Q12 && vel <= 0)) mode_q = MODE_EXT;
            end

            if (mode_q == MODE_EXT) begin
                if (divisor == 0) cmd = 0;
                else cmd = (longint'(ext_sp) * longint'(ang)) / divisor;
            end else begin
                cmd = longint'(flex_sp);
            end
            exp_res.torque_cmd  = cmd[8:0];
            exp_res.assist_mode = mode_q;
            pending_cmds.push_back(exp_res);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_out got);
            t_out exp_res;
            if (pending_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected result torque %0d mode %0b",
                                          got.torque_cmd, got.assist_mode));
            end else begin
                exp_res = pending_cmds.pop_front();
                if (got.torque_cmd !== exp_res.torque_cmd)
                    report_mismatch($sformatf("torque_cmd got %0d want %0d",
                                              got.torque_cmd, exp_res.torque_cmd));
                if (got.assist_mode !== exp_res.assist_mode)
                    report_mismatch($sformatf("assist_mode got %0b want %0b",
                                              got.assist_mode, exp_res.assist_mode));
            end
        endtask

        function int pending_count();
            return pending_cmds.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    torque_scoreboard sb = new();
    bit  no_idle = 1'b0;
    int  traj_angle = 0;
    int  traj_dir = 1;
    int  traj_amp = 8000;

    hip_extension_angle_assist_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result receiver stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else begin
                out_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    task automatic send_sample(input t_in s);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = s;
        do @(posedge i_clk); while (!in_ready);
        sb.note_sample(s);
    endtask

    task automatic send_pair(input int ang, input int vel);
        t_in s;
        s.joint_angle    = 16'(ang);
        s.joint_velocity = 16'(vel);
        send_sample(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Lower valid and wait until every predicted result has been seen
    task automatic wait_drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending_count() > 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input int ext, input int flex, input int pct, input int clr,
                                input int imax, input int imin);
        write_reg(REG_EXT_SP, 16'(ext));
        write_reg(REG_FLEX_SP, 16'(flex));
        write_reg(REG_PERCENT, 16'(pct));
        write_reg(REG_CLEAR, 16'(clr));
        write_reg(REG_INIT_MAX, 16'(imax));
        write_reg(REG_INIT_MIN, 16'(imin));
    endtask

    // Register value: an extreme a quarter of the time, raw bits otherwise
    function automatic logic [CFG_DATA_W-1:0] pick_reg_data(logic [CFG_IDX_W-1:0] idx);
        bit hi;
        hi = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) return 16'($urandom);
        case (idx)
            REG_EXT_SP, REG_FLEX_SP: return hi ? 16'(255) : 16'(-255);
            REG_PERCENT:             return hi ? 16'(100) : 16'(0);
            REG_CLEAR:               return hi ? 16'(1) : 16'(0);
            REG_INIT_MAX:            return hi ? 16'(32767) : 16'(0);
            REG_INIT_MIN:            return hi ? 16'(0) : 16'(-32768);
            default:                 return 16'($urandom);
        endcase
    endfunction

    // Swing-like trajectory: angle sweeps back and forth, velocity follows it
    function automatic t_in gait_sample();
        t_in s;
        int  vel;
        traj_angle += traj_dir * $urandom_range(20, 1500);
        if (traj_angle > traj_amp) begin
            traj_angle = traj_amp;
            traj_dir = -1;
        end else if (traj_angle < -traj_amp) begin
            traj_angle = -traj_amp;
            traj_dir = 1;
        end
        vel = traj_dir * $urandom_range(0, 3000);
        if ($urandom_range(0, 9) == 0) vel = -vel;
        s.joint_angle    = 16'(traj_angle);
        s.joint_velocity = 16'(vel);
        return s;
    endfunction

    // Stimulus
    initial begin
        t_in s;
        int  idx;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: zero range, zero setpoints
        send_pair(0, 0);
        send_pair(358, 0);
        wait_drain();

        // Register extremes, range reloaded every sample
        program_regs(255, -255, 100, 1, 32767, -32768);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(357, -1);
        send_pair(358, 0);
        send_pair(1, 32767);
        send_pair(0, 0);
        send_pair(32767, 1);
        send_pair(32767, -32768);
        wait_drain();

        // Negative extension setpoint, zero target, dropped upper bits,
        // positive initial minimum, and writes to unused indexes
        write_reg(REG_EXT_SP, 16'hFF01);
        write_reg(REG_FLEX_SP, 16'(255));
        write_reg(REG_PERCENT, 16'hFF80);
        write_reg(REG_CLEAR, 16'hFFFF);
        write_reg(REG_INIT_MAX, 16'h8000);
        write_reg(REG_INIT_MIN, 16'h1234);
        write_reg(CFG_IDX_W'(6), 16'hFFFF);
        write_reg(CFG_IDX_W'(7), 16'h5A5A);
        send_pair(-1, 5);
        send_pair(100, 0);
        send_pair(16384, -5);
        send_pair(-32768, 0);
        send_pair(0, -1);
        send_pair(1, 1);
        wait_drain();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drain();
            for (idx = 0; idx < 6; idx++) write_reg(CFG_IDX_W'(idx), pick_reg_data(CFG_IDX_W'(idx)));
            no_idle  = (ph % 4 == 3);
            traj_amp = $urandom_range(400, 32767);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // sender holds off once until the pipeline is empty
                if (ph == 2 && i == 60) wait_drain();
                if ($urandom_range(0, 9) < 7) begin
                    s = gait_sample();
                end else begin
                    s.joint_angle    = 16'($urandom);
                    s.joint_velocity = 16'($urandom);
                end
                send_sample(s);
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
